[rtl/pfwm_pkg.sv]
`timescale 1ns / 1ps
// Package for the packet FIFO with watermark flags.
// Holds item and result types, status and level codes, and the sequencer states.
// No dependencies.
package pfwm_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int ITEM_BYTES_DEFAULT = 64;

	localparam int MARK_W    = 6;
	localparam int CFG_IDX_W = 1;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_TAKEN    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_LIMIT    = 3'd4;
	localparam logic [2:0] ST_OVERSIZE = 3'd5;

	// watermark level codes
	localparam logic [1:0] LV_OFF     = 2'd0;
	localparam logic [1:0] LV_REGULAR = 2'd1;
	localparam logic [1:0] LV_MAX     = 2'd2;
	localparam logic [1:0] LV_MIN     = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  data_byte;
		logic        final_byte;
		logic [15:0] read_limit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic [2:0] status;
		logic [4:0] fill_level;
		logic [1:0] level_state;
		logic [1:0] prior_level_state;
		logic       level_changed;
	} result_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CHECK,
		FSM_STREAM
	} fsm_t;

endpackage

[rtl/packet_fifo_with_watermarks_core.sv]
`timescale 1ns / 1ps
// Packet FIFO with watermark flags: top level.
// Slot byte store, slot length store, push/pop sequencer and watermark tracker.
// Depends on pfwm_pkg.
//
//  channel   | handshake            | payload                  | direction
//  ----------+----------------------+--------------------------+----------
//  item      | start / busy         | item (in_item_t)         | in
//  result    | result_strobe        | result (result_t)        | out
//  config    | cfg_we               | cfg_index, cfg_wdata     | in
//
// A push is handled in the idle state: a new item can be accepted on every clock edge while not busy.
// A pop passes through its accept cycle, a check of the slot length read from the length
// memory, then streams one packet byte per cycle out of the byte memory; an empty or
// refused pop ends after the check.
// Each result shows in the cycle after the cycle that produced it, for one cycle.
// Reset clears pointers, counts and the watermark state; the memories are not cleared.
// The receiver cannot stall: results are never held back.
module packet_fifo_with_watermarks_core
	import pfwm_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEFAULT,
	parameter int ITEM_BYTES = ITEM_BYTES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             item,
	output logic                 result_strobe,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MARK_W-1:0]    cfg_wdata
);

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;           // slot index bits
	localparam int OW = (ITEM_BYTES > 1) ? $clog2(ITEM_BYTES) : 1; // byte offset bits
	localparam int PW = $clog2(ITEM_BYTES + 1);                    // packet length bits
	localparam int CW = $clog2(DEPTH + 1);                         // packet count bits
	localparam int LW = ((CW > MARK_W) ? CW : MARK_W) + 1;         // signed compare bits
	localparam int AW = SW + OW;

	localparam logic [SW-1:0]        LAST_SLOT = SW'(DEPTH - 1);
	localparam logic [CW-1:0]        DEPTH_C   = CW'(DEPTH);
	localparam logic [PW-1:0]        ITEM_C    = PW'(ITEM_BYTES);
	localparam logic signed [LW-1:0] DEPTH_S   = LW'(DEPTH);
	localparam logic signed [LW-1:0] NEG_ONE   = '1;
	localparam logic signed [LW-1:0] ONE_S     = LW'(1);

	// memories
	logic [7:0]    store_mem [0:(1<<AW)-1];
	logic [PW-1:0] len_mem   [0:(1<<SW)-1];

	// state
	fsm_t              state_q, state_d;
	logic [SW-1:0]     write_slot_q, write_slot_d;
	logic [SW-1:0]     read_slot_q, read_slot_d;
	logic [SW-1:0]     pop_slot_q, pop_slot_d;
	logic [CW-1:0]     count_q;
	logic [PW-1:0]     partial_q, partial_d;
	logic              dropping_q, dropping_d;
	logic [1:0]        lvl_q;
	logic [MARK_W-1:0] high_q, low_q, high_d, low_d;
	logic [PW-1:0]     pop_len_q, pop_len_d;
	logic [PW-1:0]     rd_idx_q, rd_idx_d;
	logic [1:0]        prior_q, prior_d;
	logic              changed_q, changed_d;
	logic [15:0]       limit_q, limit_d;
	logic [PW-1:0]     len_rd_q;
	logic [7:0]        byte_rd_q;
	result_t           res_q, res_d;
	logic              strobe_q, strobe_d;

	// decision signals
	logic              push_go, drop_new, drop_act, take_byte, commit;
	logic              check_now, pop_ok;
	logic [PW-1:0]     len_eff;
	logic [CW-1:0]     cnt_next;
	logic              lvl_upd;
	logic [1:0]        wm_next, wm_init;
	logic signed [LW-1:0] h_ext, l_ext, h_eff, l_eff, lvl_s;
	logic [AW-1:0]     rd_addr;

	assign busy          = (state_q != FSM_IDLE);
	assign result_strobe = strobe_q;
	assign result        = res_q;

	// Decide the push and pop outcomes for this cycle.
	always_comb begin
		push_go   = (state_q == FSM_IDLE) && start && (item.cmd == CMD_PUSH);
		drop_new  = !dropping_q &&
			(((partial_q == '0) && (count_q >= DEPTH_C)) || (partial_q >= ITEM_C));
		drop_act  = dropping_q || drop_new;
		take_byte = push_go && !drop_act;
		commit    = take_byte && item.final_byte;
		// a never-written zero length reads as one byte
		len_eff   = (len_rd_q == '0) ? PW'(1) : len_rd_q;
		check_now = (state_q == FSM_CHECK);
		pop_ok    = check_now && (count_q != '0) && (limit_q != 16'd0) &&
			(limit_q >= 16'(len_eff));
		lvl_upd   = push_go || check_now;
		cnt_next  = count_q;
		if (commit) begin
			cnt_next = count_q + CW'(1);
		end else if (pop_ok) begin
			cnt_next = count_q - CW'(1);
		end
	end

	// Clamp the marks and run the watermark state machine.
	always_comb begin
		high_d = high_q;
		low_d  = low_q;
		if (cfg_we && (cfg_index == CFG_HIGH_MARK)) begin
			high_d = cfg_wdata;
		end
		if (cfg_we && (cfg_index == CFG_LOW_MARK)) begin
			low_d = cfg_wdata;
		end
		h_ext = LW'(signed'(high_d));
		l_ext = LW'(signed'(low_d));
		if (h_ext < ONE_S) begin
			h_eff = NEG_ONE;
		end else if (h_ext > DEPTH_S) begin
			h_eff = DEPTH_S;
		end else begin
			h_eff = h_ext;
		end
		if (l_ext < 0) begin
			l_eff = NEG_ONE;
		end else if (l_ext > DEPTH_S) begin
			l_eff = DEPTH_S;
		end else begin
			l_eff = l_ext;
		end
		wm_init = ((h_eff >= ONE_S) && (l_eff >= 0) && (h_eff > l_eff)) ? LV_MIN : LV_OFF;
		lvl_s   = signed'(LW'(cnt_next));
		wm_next = lvl_q;
		if (lvl_q != LV_OFF) begin
			priority if ((l_eff < lvl_s) && (lvl_s < h_eff)) begin
				wm_next = LV_REGULAR;
			end else if (lvl_s >= h_eff) begin
				wm_next = LV_MAX;
			end else if (lvl_s <= l_eff) begin
				wm_next = LV_MIN;
			end
		end
	end

	// Sequencer: next state and result.
	always_comb begin
		state_d      = state_q;
		write_slot_d = write_slot_q;
		read_slot_d  = read_slot_q;
		pop_slot_d   = pop_slot_q;
		partial_d    = partial_q;
		dropping_d   = dropping_q;
		pop_len_d    = pop_len_q;
		rd_idx_d     = rd_idx_q;
		prior_d      = prior_q;
		changed_d    = changed_q;
		limit_d      = limit_q;
		strobe_d     = 1'b0;
		res_d        = '0;
		res_d.out_last          = 1'b1;
		res_d.fill_level        = 5'(cnt_next);
		res_d.level_state       = wm_next;
		res_d.prior_level_state = lvl_q;
		res_d.level_changed     = (wm_next != lvl_q);
		unique case (state_q)
			FSM_IDLE: begin
				if (start) begin
					if (item.cmd == CMD_PUSH) begin
						strobe_d = 1'b1;
						if (drop_act) begin
							// discard through the final byte
							res_d.status = (partial_q == '0) ? ST_FULL : ST_OVERSIZE;
							dropping_d   = !item.final_byte;
							if (item.final_byte) begin
								partial_d = '0;
							end
						end else if (item.final_byte) begin
							res_d.status = ST_DONE;
							partial_d    = '0;
							write_slot_d = (write_slot_q == LAST_SLOT) ? '0 :
								write_slot_q + SW'(1);
						end else begin
							res_d.status = ST_TAKEN;
							partial_d    = partial_q + PW'(1);
						end
					end else begin
						limit_d  = item.read_limit;
						rd_idx_d = '0;
						state_d  = FSM_CHECK;
					end
				end
			end
			FSM_CHECK: begin
				if (count_q == '0) begin
					strobe_d     = 1'b1;
					res_d.status = ST_EMPTY;
					state_d      = FSM_IDLE;
				end else if (!pop_ok) begin
					strobe_d     = 1'b1;
					res_d.status = ST_LIMIT;
					state_d      = FSM_IDLE;
				end else begin
					// byte 0 is being read now; advance the ring
					pop_slot_d  = read_slot_q;
					read_slot_d = (read_slot_q == LAST_SLOT) ? '0 : read_slot_q + SW'(1);
					pop_len_d   = len_eff;
					rd_idx_d    = PW'(1);
					prior_d     = lvl_q;
					changed_d   = (wm_next != lvl_q);
					state_d     = FSM_STREAM;
				end
			end
			FSM_STREAM: begin
				strobe_d                = 1'b1;
				res_d.out_byte          = byte_rd_q;
				res_d.out_last          = (rd_idx_q == pop_len_q);
				res_d.status            = ST_DONE;
				res_d.fill_level        = 5'(count_q);
				res_d.level_state       = lvl_q;
				res_d.prior_level_state = prior_q;
				res_d.level_changed     = changed_q;
				rd_idx_d                = rd_idx_q + PW'(1);
				if (rd_idx_q == pop_len_q) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign rd_addr = {((state_q == FSM_CHECK) ? read_slot_q : pop_slot_q), rd_idx_q[OW-1:0]};

	// Byte store: one write port for pushes, one registered read port for pops.
	always_ff @(posedge clk) begin
		if (take_byte) begin
			store_mem[{write_slot_q, partial_q[OW-1:0]}] <= item.data_byte;
		end
		byte_rd_q <= store_mem[rd_addr];
	end

	// Length store: written on commit, read at the head slot every cycle.
	always_ff @(posedge clk) begin
		if (commit) begin
			len_mem[write_slot_q] <= partial_q + PW'(1);
		end
		len_rd_q <= len_mem[read_slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			count_q      <= '0;
			partial_q    <= '0;
			dropping_q   <= 1'b0;
			high_q       <= '1;
			low_q        <= '1;
			lvl_q        <= LV_OFF;
			strobe_q     <= 1'b0;
		end else begin
			write_slot_q <= write_slot_d;
			read_slot_q  <= read_slot_d;
			count_q      <= cnt_next;
			partial_q    <= partial_d;
			dropping_q   <= dropping_d;
			high_q       <= high_d;
			low_q        <= low_d;
			strobe_q     <= strobe_d;
			// a mark write restarts the tracker as after reset
			if (cfg_we) begin
				lvl_q <= wm_init;
			end else if (lvl_upd) begin
				lvl_q <= wm_next;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pop_slot_q <= pop_slot_d;
		pop_len_q  <= pop_len_d;
		rd_idx_q   <= rd_idx_d;
		prior_q    <= prior_d;
		changed_q  <= changed_d;
		limit_q    <= limit_d;
		res_q      <= res_d;
	end

	// fill level never passes the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("packet count above depth");

	// only a pop stream gives results that are not the last of their item
	a_stream_only: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.out_last) |-> (state_q == FSM_STREAM))
		else $error("non-final result outside a pop stream");

	// the stream index never runs past the packet length
	a_stream_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_STREAM) |-> (rd_idx_q <= pop_len_q) && (rd_idx_q != '0))
		else $error("stream index out of range");

	// the packet count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
		(count_q == $past(count_q) - CW'(1)))
		else $error("packet count jumped");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for packet_fifo_with_watermarks_core: streams push and pop items
// into the core and checks every result against a behavioral FIFO/watermark model.
// Depends on pfwm_pkg and the core RTL.
module testbench;
	import pfwm_pkg::*;

	localparam int NSLOT         = DEPTH_DEFAULT;
	localparam int SLOT_BYTES    = ITEM_BYTES_DEFAULT;
	localparam int STALL_LIMIT   = 1000;  // cycles with no item, result or write
	localparam int SETTLE_CYCLES = 8;     // covers fetch plus result delay
	localparam int IDLE_PCT      = 27;
	localparam int REPORT_MAX    = 10;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	in_item_t             item      = '0;
	logic                 result_strobe;
	result_t              result;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_HIGH_MARK;
	logic [MARK_W-1:0]    cfg_wdata = '0;

	packet_fifo_with_watermarks_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial forever #2 clk = ~clk;

	// ------------------------------------------------------------------
	// FIFO and watermark model
	// ------------------------------------------------------------------
	logic [7:0]               model_bytes [NSLOT][SLOT_BYTES];
	int                       model_len [NSLOT];
	int                       wr_slot     = 0;
	int                       rd_slot     = 0;
	int                       held_pkts   = 0;
	int                       partial_len = 0;
	bit                       drop_active = 1'b0;
	logic [1:0]               wm_level;
	logic signed [MARK_W-1:0] high_reg;
	logic signed [MARK_W-1:0] low_reg;

	result_t expected_results[$];
	int      mismatches = 0;

	// A high mark below one reads as -1 (disabled); anything past the depth clamps to the depth.
	function automatic int high_threshold();
		int h;
		h = high_reg;
		if (h < 1) return -1;
		return (h > NSLOT) ? NSLOT : h;
	endfunction

	function automatic int low_threshold();
		int l;
		l = low_reg;
		if (l < 0) return -1;
		return (l > NSLOT) ? NSLOT : l;
	endfunction

	// Tracking only runs when both marks are live and properly ordered.
	function automatic logic [1:0] restart_level();
		int h;
		int l;
		h = high_threshold();
		l = low_threshold();
		return (h >= 1 && l >= 0 && h > l) ? LV_MIN : LV_OFF;
	endfunction

	// Any mark write restarts the watermark tracker; FIFO contents stay.
	task automatic apply_mark_write(logic [CFG_IDX_W-1:0] idx, logic [MARK_W-1:0] value);
		if (idx == CFG_HIGH_MARK) high_reg = value;
		else if (idx == CFG_LOW_MARK) low_reg = value;
		wm_level = restart_level();
	endtask

	// Advance the model by one accepted item and queue the results it owes.
	task automatic predict_fifo_item(in_item_t it);
		logic [2:0] st;
		logic [1:0] prior;
		logic [1:0] next_level;
		bit         changed;
		int         pop_slot;
		int         pop_count;
		int         h;
		int         l;
		int         i;
		result_t    r;
		prior     = wm_level;
		changed   = 1'b0;
		pop_slot  = 0;
		pop_count = 0;
		if (it.cmd == CMD_PUSH) begin
			// A packet starting on a full FIFO, or growing past a slot, is
			// discarded through its final byte.
			if (!drop_active && partial_len == 0 && held_pkts >= NSLOT)
				drop_active = 1'b1;
			else if (!drop_active && partial_len >= SLOT_BYTES)
				drop_active = 1'b1;
			if (drop_active) begin
				st = (partial_len == 0) ? ST_FULL : ST_OVERSIZE;
				if (it.final_byte) begin
					drop_active = 1'b0;
					partial_len = 0;
				end
			end else begin
				model_bytes[wr_slot][partial_len] = it.data_byte;
				partial_len++;
				if (it.final_byte) begin
					model_len[wr_slot] = partial_len;
					wr_slot            = (wr_slot + 1) % NSLOT;
					held_pkts++;
					partial_len = 0;
					st          = ST_DONE;
				end else begin
					st = ST_TAKEN;
				end
			end
		end else if (held_pkts == 0) begin
			st = ST_EMPTY;
		end else if (it.read_limit == 0 || it.read_limit < model_len[rd_slot]) begin
			// Refused pop keeps the packet at the head.
			st = ST_LIMIT;
		end else begin
			st        = ST_DONE;
			pop_slot  = rd_slot;
			pop_count = model_len[rd_slot];
			rd_slot   = (rd_slot + 1) % NSLOT;
			held_pkts--;
		end

		if (wm_level != LV_OFF) begin
			next_level = wm_level;
			h          = high_threshold();
			l          = low_threshold();
			if (l < held_pkts && held_pkts < h) next_level = LV_REGULAR;
			else if (held_pkts >= h) next_level = LV_MAX;
			else if (held_pkts <= l) next_level = LV_MIN;
			changed  = (next_level != wm_level);
			wm_level = next_level;
		end

		r.out_byte          = 8'h00;
		r.out_last          = 1'b1;
		r.status            = st;
		r.fill_level        = 5'(held_pkts);
		r.level_state       = wm_level;
		r.prior_level_state = prior;
		r.level_changed     = changed;
		if (pop_count == 0) begin
			expected_results.push_back(r);
		end else begin
			for (i = 0; i < pop_count; i++) begin
				r.out_byte = model_bytes[pop_slot][i];
				r.out_last = (i == pop_count - 1);
				expected_results.push_back(r);
			end
		end
	endtask

	// Compare one result with the oldest expectation, field by field.
	task automatic check_result(result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("unexpected result: byte %02h last %0d status %0d fill %0d",
					got.out_byte, got.out_last, got.status, got.fill_level);
			return;
		end
		want = expected_results.pop_front();
		if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
				got.status !== want.status || got.fill_level !== want.fill_level ||
				got.level_state !== want.level_state ||
				got.prior_level_state !== want.prior_level_state ||
				got.level_changed !== want.level_changed) begin
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$display("mismatch at %0t: byte/last/status/fill/level/prior/changed", $realtime);
				$display("  want %02h %0d %0d %0d %0d %0d %0d", want.out_byte, want.out_last,
					want.status, want.fill_level, want.level_state,
					want.prior_level_state, want.level_changed);
				$display("  got  %02h %0d %0d %0d %0d %0d %0d", got.out_byte, got.out_last,
					got.status, got.fill_level, got.level_state,
					got.prior_level_state, got.level_changed);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: present items from the pending queue at the falling edge
	// ------------------------------------------------------------------
	in_item_t pending_items[$];
	bit       item_taken   = 1'b0;  // handshake seen at the last rising edge
	bit       steady_feed  = 1'b0;  // suppress random idling
	int       items_queued = 0;
	int       items_taken  = 0;

	// Hold the current item until taken, then either idle or load the next.
	// start gets at most one assignment per edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			if (pending_items.size() != 0 &&
					(steady_feed || $urandom_range(99) >= IDLE_PCT)) begin
				item  <= pending_items.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample handshakes at the rising edge, predict and check
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		item_taken = arst_n && start && !busy;
		if (arst_n && cfg_we)
			apply_mark_write(cfg_index, cfg_wdata);
		if (item_taken) begin
			items_taken++;
			predict_fifo_item(item);
		end
		if (arst_n && result_strobe === 1'b1)
			check_result(result);
	end

	// Watchdog: end the run if the core stops moving.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe === 1'b1 || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: core stalled with %0d results outstanding",
				expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_item(logic cmd, logic [7:0] b, logic fin, logic [15:0] lim);
		in_item_t it;
		it.cmd        = cmd;
		it.data_byte  = b;
		it.final_byte = fin;
		it.read_limit = lim;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Mostly roomy limits; some zero, tiny or saturated to hit refusals.
	function automatic logic [15:0] pick_read_limit();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 16'($urandom_range(65535));
		if (r < 72) return 16'h0000;
		if (r < 90) return 16'($urandom_range(1, 6));
		return 16'hFFFF;
	endfunction

	// Short packets dominate so the FIFO can fill and drain often.
	function automatic int pick_packet_len();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(1, 4);
		if (r < 94) return $urandom_range(5, 16);
		return $urandom_range(17, SLOT_BYTES);
	endfunction

	// Queue one packet; occasionally slip a pop in between its bytes.
	task automatic queue_packet(int len, int pop_pct);
		int i;
		for (i = 0; i < len; i++) begin
			queue_item(CMD_PUSH, 8'($urandom_range(255)), i == len - 1,
				16'($urandom_range(65535)));
			if (i != len - 1 && $urandom_range(99) < pop_pct)
				queue_item(CMD_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
					pick_read_limit());
		end
	endtask

	task automatic queue_random_phase(int n_items, int push_pct);
		int goal;
		goal = items_queued + n_items;
		while (items_queued < goal) begin
			if ($urandom_range(99) < push_pct)
				queue_packet(pick_packet_len(), 8);
			else
				queue_item(CMD_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
					pick_read_limit());
		end
	endtask

	// Wait until every queued item is taken and every result has arrived.
	task automatic wait_drained();
		while (items_taken != items_queued || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Drain, let the core go quiet, then write both marks.
	task automatic settle_then_write(logic [MARK_W-1:0] high_val, logic [MARK_W-1:0] low_val);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_HIGH_MARK;
		cfg_wdata <= high_val;
		@(negedge clk);
		cfg_index <= CFG_LOW_MARK;
		cfg_wdata <= low_val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		high_reg = '1;
		low_reg  = '1;
		wm_level = restart_level();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, marks still at reset (tracker off).
		queue_item(CMD_POP,  8'h00, 1'b0, 16'h0000);  // pop on empty FIFO
		queue_item(CMD_PUSH, 8'h00, 1'b1, 16'h0000);  // one-byte packet
		queue_item(CMD_PUSH, 8'hFF, 1'b0, 16'hFFFF);
		queue_item(CMD_PUSH, 8'hA5, 1'b1, 16'hFFFF);  // two-byte packet
		queue_item(CMD_POP,  8'hFF, 1'b1, 16'h0000);  // zero limit: refused
		queue_item(CMD_POP,  8'h00, 1'b0, 16'd1);     // limit just fits
		queue_item(CMD_POP,  8'h00, 1'b0, 16'd1);     // limit below length
		queue_item(CMD_PUSH, 8'h5A, 1'b0, 16'h0000);  // open a packet
		queue_item(CMD_POP,  8'h00, 1'b0, 16'd2);     // pop while a push is open
		queue_item(CMD_POP,  8'h00, 1'b0, 16'hFFFF);  // empty while push is open
		queue_item(CMD_PUSH, 8'h3C, 1'b1, 16'h0000);  // close it

		// Walk the watermark from min, through regular, to max and back.
		settle_then_write(6'd3, 6'd1);
		repeat (4) queue_item(CMD_PUSH, 8'($urandom_range(255)), 1'b1, 16'h0000);
		repeat (5) queue_item(CMD_POP, 8'h00, 1'b0, 16'hFFFF);

		// Tracker off; start with an oversize packet on the now empty FIFO.
		settle_then_write(6'h3F, 6'h3F);
		queue_packet(SLOT_BYTES + 3, 0);
		queue_random_phase(25, 60);

		// Widest valid window; push hard to reach full and drop packets.
		settle_then_write(6'd16, 6'd0);
		queue_random_phase(35, 85);

		// Back-to-back feed with a mid-range window.
		settle_then_write(6'd10, 6'd3);
		steady_feed = 1'b1;
		queue_random_phase(30, 50);
		wait_drained();
		steady_feed = 1'b0;

		// High mark at its most negative: tracker off; mostly drain.
		settle_then_write(6'h20, 6'd5);
		queue_random_phase(25, 25);

		// Narrowest window.
		settle_then_write(6'd1, 6'd0);
		queue_random_phase(25, 55);

		// Both marks beyond depth clamp to equal: off; then inverted: off.
		settle_then_write(6'd31, 6'd31);
		queue_random_phase(10, 60);
		settle_then_write(6'd12, 6'd16);
		queue_random_phase(10, 60);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
